### rtl/core/group_bitmap_block_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Define NO_ASSERTIONS to compile the checks out; expects clk and arst_n in scope.
`ifndef GROUP_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define GROUP_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check on every rising edge, off while reset is asserted.
`define GBBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check on every rising edge, reset included.
`define GBBA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBBA_ASSERT(lbl, prop, msg)
`define GBBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/gbba_pkg.sv
// Shared types, codes and defaults of the group bitmap block allocator.
// No dependencies.
package gbba_pkg;

	localparam int GBBA_MAX_GROUPS = 8;
	localparam int GBBA_MAX_BPG    = 8192;

	// Width of an effective group size (holds the largest MAX_BLOCKS_PER_GROUP)
	localparam int BPG_W = 16;

	typedef enum logic [1:0] {
		REQ_LOAD_WORD  = 2'd0,
		REQ_LOAD_COUNT = 2'd1,
		REQ_ALLOC      = 2'd2,
		REQ_NONE       = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_LOAD_DONE = 2'd0,
		ST_ALLOCATED = 2'd1,
		ST_NO_SPACE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_TOTAL_BLOCKS = 2'd0,
		CFG_BPG          = 2'd1,
		CFG_ONE_OFFSET   = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

	// Settings after clamping, as the engine uses them
	typedef struct packed {
		logic [16:0]      total;
		logic [BPG_W-1:0] bpg;
		logic             one_offset;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [2:0]  group;
		logic [6:0]  word_index;
		logic [63:0] word_data;
		logic [13:0] free_count;
	} req_fields_t;

endpackage

### rtl/core/gbba_cfg.sv
// Configuration registers of the allocator and the group size clamp.
// Depends on gbba_pkg.
module gbba_cfg import gbba_pkg::*; #(
	parameter int MAX_BLOCKS_PER_GROUP = GBBA_MAX_BPG
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [16:0] cfg_wdata,
	output cfg_t        cfg
);

	localparam logic [BPG_W-1:0] BPG_MAX = BPG_W'(MAX_BLOCKS_PER_GROUP);
	localparam logic [BPG_W-1:0] BPG_MIN = BPG_W'(64);

	logic [16:0]      total_q;
	logic [13:0]      bpg_q;
	logic             offset_q;
	logic [BPG_W-1:0] bpg_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= 17'd65536;
			bpg_q    <= 14'd8192;
			offset_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_TOTAL_BLOCKS: total_q  <= cfg_wdata;
				CFG_BPG:          bpg_q    <= cfg_wdata[13:0];
				CFG_ONE_OFFSET:   offset_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Clamp the group size into [64, MAX_BLOCKS_PER_GROUP]
	always_comb begin
		bpg_ext = BPG_W'(bpg_q);
		cfg.total = total_q;
		cfg.one_offset = offset_q;
		priority if (bpg_ext < BPG_MIN) cfg.bpg = BPG_MIN;
		else if (bpg_ext > BPG_MAX)     cfg.bpg = BPG_MAX;
		else                            cfg.bpg = bpg_ext;
	end

endmodule

### rtl/core/gbba_ffs.sv
// Lowest free block finder for one 64-bit bitmap word, masked to the group end.
// Depends on gbba_pkg.
module gbba_ffs import gbba_pkg::*; (
	input  logic [63:0]      word,
	input  logic [BPG_W-1:0] remain,
	output logic             found,
	output logic [5:0]       bit_idx
);

	logic [63:0] mask;
	logic [63:0] avail;
	logic [63:0] iso;

	always_comb begin
		if (remain < BPG_W'(64)) mask = (64'd1 << remain[5:0]) - 64'd1;
		else                     mask = '1;
		avail = ~word & mask;
		// isolate the lowest set bit
		iso   = avail & (~avail + 64'd1);
		found = |avail;
		bit_idx = '0;
		for (int i = 0; i < 64; i++) begin
			if (iso[i]) bit_idx = bit_idx | 6'(i);
		end
	end

endmodule

### rtl/core/gbba_engine.sv
// Allocation engine: bitmap and count memories, read-modify-write sequencer,
// output register. Depends on gbba_pkg, gbba_ffs and the assertion macros.
`include "group_bitmap_block_allocator_defines.svh"
module gbba_engine import gbba_pkg::*; #(
	parameter int MAX_GROUPS           = GBBA_MAX_GROUPS,
	parameter int MAX_BLOCKS_PER_GROUP = GBBA_MAX_BPG
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_fields_t in_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_status,
	output logic [16:0] out_block,
	output logic [13:0] out_left
);

	localparam int WPG   = MAX_BLOCKS_PER_GROUP / 64;
	localparam int DEPTH = MAX_GROUPS * WPG;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GC_W  = $clog2(MAX_GROUPS + 1);
	localparam int GB_W  = $clog2(MAX_GROUPS * MAX_BLOCKS_PER_GROUP + 1);
	localparam int CMP_W = (GB_W > 17) ? GB_W : 17;

	localparam logic [AW:0]     LAST_A = (AW+1)'(DEPTH - 1);
	localparam logic [AW:0]     MG_A   = (AW+1)'(MAX_GROUPS);
	localparam logic [AW:0]     WPG_A  = (AW+1)'(WPG);
	localparam logic [GC_W-1:0] MG_G   = GC_W'(MAX_GROUPS);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_GRP, S_CNT, S_WRD, S_WCHK, S_SET, S_RESP
	} state_t;

	state_t st_q;

	logic [AW:0]        clr_q;
	logic [GC_W-1:0]    g_q;
	logic [CMP_W-1:0]   gbase_q;
	logic [AW:0]        gaddr_q;
	logic [AW:0]        waddr_q;
	logic [BPG_W:0]     woff_q;
	logic [13:0]        cnt_q;
	logic [63:0]        word_q;
	logic [5:0]         bit_q;
	logic [1:0]         res_status_q;
	logic [16:0]        res_block_q;
	logic [13:0]        res_left_q;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [16:0]        out_block_q;
	logic [13:0]        out_left_q;

	// Bitmap memory
	logic [63:0]   bm_mem [DEPTH];
	logic [63:0]   bm_rdata_q;
	logic          bm_we;
	logic [AW-1:0] bm_waddr;
	logic [63:0]   bm_wdata;

	// Group free count memory
	logic [13:0]   cnt_mem [MAX_GROUPS];
	logic [13:0]   cnt_rdata_q;
	logic          cnt_we;
	logic [GW-1:0] cnt_waddr;
	logic [13:0]   cnt_wdata;

	logic             accept;
	logic             grp_ok;
	logic             word_ok;
	logic [AW-1:0]    load_addr;
	logic [BPG_W-1:0] remain;
	logic             ffs_found;
	logic [5:0]       ffs_bit;
	logic [CMP_W-1:0] blk_sum;
	logic             slot_free;

	assign in_ready  = (st_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign grp_ok    = int'(in_req.group) < MAX_GROUPS;
	assign word_ok   = int'(in_req.word_index) < WPG;
	assign load_addr = AW'(int'(in_req.group) * WPG + int'(in_req.word_index));
	assign remain    = cfg.bpg - woff_q[BPG_W-1:0];
	assign blk_sum   = gbase_q + CMP_W'(woff_q) + CMP_W'(bit_q) + CMP_W'(cfg.one_offset);
	assign slot_free = !out_valid_q || out_ready;

	gbba_ffs u_ffs (
		.word    (bm_rdata_q),
		.remain  (remain),
		.found   (ffs_found),
		.bit_idx (ffs_bit)
	);

	// Memory write port select: clearing pass, load, or allocation update
	always_comb begin
		bm_we     = 1'b0;
		bm_waddr  = load_addr;
		bm_wdata  = in_req.word_data;
		cnt_we    = 1'b0;
		cnt_waddr = GW'(in_req.group);
		cnt_wdata = in_req.free_count;
		priority case (st_q)
			S_CLEAR: begin
				bm_we     = 1'b1;
				bm_waddr  = clr_q[AW-1:0];
				bm_wdata  = '0;
				cnt_we    = clr_q < MG_A;
				cnt_waddr = GW'(clr_q);
				cnt_wdata = '0;
			end
			S_SET: begin
				bm_we     = 1'b1;
				bm_waddr  = waddr_q[AW-1:0];
				bm_wdata  = word_q | (64'd1 << bit_q);
				cnt_we    = 1'b1;
				cnt_waddr = GW'(g_q);
				cnt_wdata = cnt_q - 14'd1;
			end
			default: begin
				bm_we  = accept && (in_req.req_type == REQ_LOAD_WORD) && grp_ok && word_ok;
				cnt_we = accept && (in_req.req_type == REQ_LOAD_COUNT) && grp_ok;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
		bm_rdata_q <= bm_mem[waddr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rdata_q <= cnt_mem[GW'(g_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_CLEAR;
			clr_q        <= '0;
			g_q          <= '0;
			gbase_q      <= '0;
			gaddr_q      <= '0;
			waddr_q      <= '0;
			woff_q       <= '0;
			cnt_q        <= '0;
			word_q       <= '0;
			bit_q        <= '0;
			res_status_q <= ST_LOAD_DONE;
			res_block_q  <= '0;
			res_left_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_LOAD_DONE;
			out_block_q  <= '0;
			out_left_q   <= '0;
		end else begin
			// drop valid once the result transfer completes; S_RESP reloads it itself
			if (out_valid_q && out_ready && st_q != S_RESP) out_valid_q <= 1'b0;
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_A) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						g_q     <= '0;
						gbase_q <= '0;
						gaddr_q <= '0;
						waddr_q <= '0;
						res_status_q <= ST_LOAD_DONE;
						res_block_q  <= '0;
						res_left_q   <= '0;
						if (in_req.req_type == REQ_ALLOC) st_q <= S_GRP;
						else                              st_q <= S_RESP;
					end
				end
				S_GRP: begin
					// count read of group g_q is issued this cycle
					if (g_q >= MG_G || gbase_q >= CMP_W'(cfg.total)) begin
						res_status_q <= ST_NO_SPACE;
						st_q <= S_RESP;
					end else begin
						st_q <= S_CNT;
					end
				end
				S_CNT: begin
					cnt_q   <= cnt_rdata_q;
					waddr_q <= gaddr_q;
					woff_q  <= '0;
					if (cnt_rdata_q == '0) begin
						g_q     <= g_q + 1'b1;
						gbase_q <= gbase_q + CMP_W'(cfg.bpg);
						gaddr_q <= gaddr_q + WPG_A;
						st_q    <= S_GRP;
					end else begin
						st_q <= S_WRD;
					end
				end
				S_WRD: begin
					// bitmap read of waddr_q is issued this cycle
					if (woff_q >= (BPG_W+1)'(cfg.bpg)) begin
						g_q     <= g_q + 1'b1;
						gbase_q <= gbase_q + CMP_W'(cfg.bpg);
						gaddr_q <= gaddr_q + WPG_A;
						st_q    <= S_GRP;
					end else begin
						st_q <= S_WCHK;
					end
				end
				S_WCHK: begin
					word_q <= bm_rdata_q;
					bit_q  <= ffs_bit;
					if (ffs_found) begin
						st_q <= S_SET;
					end else begin
						waddr_q <= waddr_q + 1'b1;
						woff_q  <= woff_q + (BPG_W+1)'(64);
						st_q    <= S_WRD;
					end
				end
				S_SET: begin
					res_status_q <= ST_ALLOCATED;
					res_block_q  <= blk_sum[16:0];
					res_left_q   <= cnt_q - 14'd1;
					st_q <= S_RESP;
				end
				S_RESP: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_block_q  <= res_block_q;
						out_left_q   <= res_left_q;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_block  = out_block_q;
	assign out_left   = out_left_q;

	`GBBA_ASSERT(a_set_one_bit, (st_q == S_SET) |-> $onehot(bm_wdata ^ word_q), "allocation must set exactly one clear bit")
	`GBBA_ASSERT(a_set_count_nonzero, (st_q == S_SET) |-> (cnt_q != 14'd0), "allocation from a group with zero free count")
	`GBBA_ASSERT_ALWAYS(a_clear_complete, $fell(st_q == S_CLEAR) |-> ($past(clr_q) == LAST_A), "clearing pass left before the last bitmap word")

endmodule

### rtl/core/group_bitmap_block_allocator.sv
// Top level of the first-fit group bitmap block allocator.
// Depends on gbba_pkg, gbba_cfg and gbba_engine (which uses gbba_ffs).
//
// Channel   Dir  Handshake         Payload
// s_*       in   tvalid/tready     tuser: req_type; tdata: group, word_index,
//                                  word_data, free_count
// m_*       out  tvalid/tready     tuser: status; tdata: block_number,
//                                  group_free_left
// cfg_*     in   cfg_we (no wait)  cfg_addr: register index; cfg_wdata: value
//
// Sequence: a load or an unknown request goes from its transfer through S_RESP to the
// output register. An allocation passes S_GRP and S_CNT per group probed, S_WRD and
// S_WCHK per bitmap word read, S_WRD once more per group whose words run out, then
// S_SET and S_RESP; the bitmap memory has a single read port, so words are read one by one.
// Reset: the bitmap and count memories are zeroed by a clearing pass over all
// MAX_GROUPS * MAX_BLOCKS_PER_GROUP / 64 bitmap words (1024 by default) with
// s_tready low; configuration writes are taken throughout.
// Stalls: a finished result waits in the output register while the next
// request is accepted; a second result holds the engine until m_tready.
module group_bitmap_block_allocator import gbba_pkg::*; #(
	parameter int MAX_GROUPS           = GBBA_MAX_GROUPS,
	parameter int MAX_BLOCKS_PER_GROUP = GBBA_MAX_BPG
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // group[2:0], word_index[9:3], word_data[73:10],
	                               // free_count[87:74]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // block_number[16:0], group_free_left[30:17], zero[31]
	output logic [1:0]  m_tuser,   // status[1:0]
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [16:0] cfg_wdata
);

	cfg_t        cfg;
	req_fields_t req;
	logic [16:0] block_number;
	logic [13:0] group_free_left;

	// Unpack the request transfer into its fields
	always_comb begin
		req.req_type   = s_tuser;
		req.group      = s_tdata[2:0];
		req.word_index = s_tdata[9:3];
		req.word_data  = s_tdata[73:10];
		req.free_count = s_tdata[87:74];
	end

	gbba_cfg #(
		.MAX_BLOCKS_PER_GROUP (MAX_BLOCKS_PER_GROUP)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gbba_engine #(
		.MAX_GROUPS           (MAX_GROUPS),
		.MAX_BLOCKS_PER_GROUP (MAX_BLOCKS_PER_GROUP)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (req),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_block  (block_number),
		.out_left   (group_free_left)
	);

	// Pack the result, pad to whole bytes
	assign m_tdata = {1'b0, group_free_left, block_number};

endmodule

### sim/group_bitmap_block_allocator_tb.sv
// Self-checking testbench for the group bitmap block allocator: a directed table, then
// random phases under changing settings, results compared with a predictor or typed answers.
// Depends on gbba_pkg and the group_bitmap_block_allocator RTL.
module group_bitmap_block_allocator_tb;
	import gbba_pkg::*;

	localparam int WORDS_PER_GROUP = GBBA_MAX_BPG / 64;
	localparam int BITMAP_WORDS    = GBBA_MAX_GROUPS * WORDS_PER_GROUP;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 235;
	localparam int REPORT_LIMIT    = 10;
	// Worst allocation scans all 8 groups of 128 words; the limit leaves room for 1900 items,
	// the longest stalls and gaps, and the clearing pass.
	localparam int unsigned CYCLE_LIMIT = 20_000_000;

	typedef struct packed {
		status_t     st;
		logic [16:0] blk;
		logic [13:0] left;
	} result_t;

	// One line of the directed table: a register write or a request, with an
	// optional hand-typed answer
	typedef struct {
		bit          is_cfg;
		cfg_idx_t    cfg_idx;
		logic [16:0] cfg_val;
		req_fields_t req;
		bit          typed;
		result_t     want;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;   // group[2:0], word_index[9:3], word_data[73:10], free_count[87:74]
	logic [1:0]  s_tuser;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // block_number[16:0], group_free_left[30:17], zero[31]
	logic [1:0]  m_tuser;   // status[1:0]
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [16:0] cfg_wdata;

	group_bitmap_block_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state: its own copy of the bitmap, the counts and the settings
	logic [63:0] used_words [BITMAP_WORDS];
	logic [13:0] free_counts [GBBA_MAX_GROUPS];
	int unsigned total_blocks_m;
	int unsigned bpg_m;
	int unsigned one_offset_m;

	result_t     results_due[$];
	table_row_t  directed[$];
	int unsigned error_count;
	int unsigned cycle_count;
	int          stall_left;
	bit          quiet;
	result_t     got;
	result_t     want;

	always #10 clk = ~clk;

	// First-fit search over the groups in order; marks the block and takes one off the count
	function automatic result_t allocate_first_fit();
		int unsigned bpg;
		int unsigned groups;
		int unsigned nwords;
		int unsigned remain;
		int unsigned idx;
		int unsigned b;
		int unsigned blk_full;
		logic [63:0] avail;
		result_t     res;
		res.st   = ST_NO_SPACE;
		res.blk  = '0;
		res.left = '0;
		bpg = bpg_m;
		if (bpg < 64)
			bpg = 64;
		if (bpg > GBBA_MAX_BPG)
			bpg = GBBA_MAX_BPG;
		groups = (total_blocks_m + bpg - 1) / bpg;
		if (groups > GBBA_MAX_GROUPS)
			groups = GBBA_MAX_GROUPS;
		nwords = (bpg + 63) / 64;
		for (int unsigned g = 0; g < groups; g++) begin
			if (free_counts[g] == 0)
				continue;
			for (int unsigned w = 0; w < nwords; w++) begin
				idx    = g * WORDS_PER_GROUP + w;
				remain = bpg - w * 64;
				avail  = ~used_words[idx];
				// a group size that is not a multiple of 64 cuts the last word short
				if (remain < 64)
					avail = avail & ((64'd1 << remain) - 64'd1);
				if (avail == 64'd0)
					continue;
				b = 0;
				while (!avail[b])
					b++;
				used_words[idx][b] = 1'b1;
				free_counts[g] = free_counts[g] - 14'd1;
				blk_full = g * bpg + w * 64 + b + one_offset_m;
				res.st   = ST_ALLOCATED;
				res.blk  = blk_full[16:0];
				res.left = free_counts[g];
				return res;
			end
		end
		return res;
	endfunction

	function automatic result_t predict_request(input req_fields_t r);
		result_t res;
		res.st   = ST_LOAD_DONE;
		res.blk  = '0;
		res.left = '0;
		case (r.req_type)
			REQ_LOAD_WORD: used_words[r.group * WORDS_PER_GROUP + r.word_index] = r.word_data;
			REQ_LOAD_COUNT: free_counts[r.group] = r.free_count;
			REQ_ALLOC: res = allocate_first_fit();
			default: ;
		endcase
		return res;
	endfunction

	function automatic table_row_t req_row(input req_t rt, input int grp, input int widx,
			input logic [63:0] data, input int cnt, input bit typed, input status_t st,
			input int blk, input int left);
		table_row_t row;
		row.is_cfg         = 1'b0;
		row.cfg_idx        = CFG_UNUSED;
		row.cfg_val        = '0;
		row.req.req_type   = rt;
		row.req.group      = grp[2:0];
		row.req.word_index = widx[6:0];
		row.req.word_data  = data;
		row.req.free_count = cnt[13:0];
		row.typed          = typed;
		row.want.st        = st;
		row.want.blk       = blk[16:0];
		row.want.left      = left[13:0];
		return row;
	endfunction

	function automatic table_row_t cfg_row(input cfg_idx_t idx, input int val);
		table_row_t row;
		row        = req_row(REQ_NONE, 0, 0, 64'd0, 0, 1'b0, ST_LOAD_DONE, 0, 0);
		row.is_cfg  = 1'b1;
		row.cfg_idx = idx;
		row.cfg_val = val[16:0];
		return row;
	endfunction

	// Mostly loads near the start of the bitmaps and allocations, so that the search
	// runs into full words, spent counts and fresh blocks; a few unknown requests
	function automatic req_fields_t random_request();
		req_fields_t r;
		int unsigned pick;
		r.req_type   = REQ_ALLOC;
		r.group      = 3'($urandom);
		r.word_index = 7'($urandom);
		r.word_data  = {$urandom, $urandom};
		r.free_count = 14'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			r.req_type = REQ_LOAD_WORD;
			if ($urandom_range(0, 9) < 7)
				r.word_index = 7'($urandom_range(0, 3));
			case ($urandom_range(0, 4))
				0: r.word_data = '1;
				1: r.word_data = '0;
				2: r.word_data = {$urandom, $urandom};
				3: r.word_data = ~(64'd1 << $urandom_range(0, 63));
				default: r.word_data = {$urandom, $urandom} | {$urandom, $urandom};
			endcase
		end else if (pick < 40) begin
			r.req_type = REQ_LOAD_COUNT;
			case ($urandom_range(0, 9))
				0: r.free_count = 14'($urandom);
				1: r.free_count = $urandom_range(0, 1) ? 14'd8192 : 14'd16383;
				default: r.free_count = 14'($urandom_range(0, 6));
			endcase
		end else if (pick >= 95) begin
			r.req_type = REQ_NONE;
		end
		return r;
	endfunction

	// Drop valid at the next falling edge and hold it low for the rest of the gap
	task automatic pause_sender(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Hold valid low until every expected result has been taken
	task automatic drain_results();
		pause_sender(1);
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val[16:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TOTAL_BLOCKS: total_blocks_m = val & 32'h1FFFF;
			CFG_BPG:          bpg_m = val & 32'h3FFF;
			CFG_ONE_OFFSET:   one_offset_m = val & 1;
			default: ;
		endcase
	endtask

	// Present one request and wait for its transfer; the answer is queued at that edge
	task automatic send_request(input req_fields_t r, input bit typed, input result_t typed_want);
		result_t res;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= r.req_type;
		s_tdata  <= {r.free_count, r.word_data, r.word_index, r.group};
		do @(posedge clk); while (!s_tready);
		res = predict_request(r);
		if (typed)
			res = typed_want;
		results_due.push_back(res);
	endtask

	// Receiver: random stall bursts on m_tready, none once quiet is set
	always @(negedge clk) begin
		if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 6);
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.st   = status_t'(m_tuser);
			got.blk  = m_tdata[16:0];
			got.left = m_tdata[30:17];
			if (results_due.size() == 0) begin
				if (error_count < REPORT_LIMIT)
					$display("unexpected result: status %0d block %0d left %0d",
						got.st, got.blk, got.left);
				error_count++;
			end else begin
				want = results_due.pop_front();
				if (got.st != want.st || got.blk != want.blk || got.left != want.left) begin
					if (error_count < REPORT_LIMIT)
						$display("mismatch: expected status %0d block %0d left %0d, got %0d %0d %0d",
							want.st, want.blk, want.left, got.st, got.blk, got.left);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned phase_total [RANDOM_PHASES];
		int unsigned phase_bpg [RANDOM_PHASES];
		int unsigned phase_off [RANDOM_PHASES];
		table_row_t  row;

		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = REQ_NONE;
		m_tready   = 1'b0;
		cfg_we     = 1'b0;
		cfg_addr   = CFG_TOTAL_BLOCKS;
		cfg_wdata  = '0;
		stall_left = 0;
		quiet      = 1'b0;
		error_count = 0;
		cycle_count = 0;
		for (int i = 0; i < BITMAP_WORDS; i++)
			used_words[i] = '0;
		for (int i = 0; i < GBBA_MAX_GROUPS; i++)
			free_counts[i] = '0;
		total_blocks_m = 65536;
		bpg_m          = 8192;
		one_offset_m   = 1;

		// Settings per random phase: extremes, clamped group sizes, no groups at all,
		// a group size that is not a multiple of 64; the last phase runs without idling
		phase_total = '{65536, 512, 131071, 300, 1, 0, 65536, 1000};
		phase_bpg   = '{8192, 64, 0, 100, 16383, 64, 128, 200};
		phase_off   = '{1, 0, 1, 1, 0, 1, 0, 1};

		// Directed table, starting from the reset settings (65536 blocks, 8192 per group,
		// offset on); typed answers follow from the bitmap and counts at a glance
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_NO_SPACE, 0, 0));
		directed.push_back(req_row(REQ_NONE, 7, 127, '1, 16383, 1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_LOAD_COUNT, 0, 0, 64'd0, 3, 1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_ALLOCATED, 1, 2));
		directed.push_back(req_row(REQ_LOAD_WORD, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0,
			1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_ALLOCATED, 64, 1));
		// word 0 is full now: move to word 1
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_ALLOCATED, 65, 0));
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_NO_SPACE, 0, 0));
		directed.push_back(req_row(REQ_LOAD_COUNT, 7, 0, 64'd0, 16383, 1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_LOAD_WORD, 7, 127, '1, 0, 1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_ALLOCATED, 57345, 16382));
		directed.push_back(req_row(REQ_LOAD_WORD, 7, 0, '1, 0, 1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_ALLOCATED, 57409, 16381));
		// group size zero is taken as 64; offset off
		directed.push_back(cfg_row(CFG_BPG, 0));
		directed.push_back(cfg_row(CFG_ONE_OFFSET, 0));
		directed.push_back(req_row(REQ_LOAD_COUNT, 0, 0, 64'd0, 5, 1, ST_LOAD_DONE, 0, 0));
		// groups 0 and 7 have counts but no clear bit: counts stay, no space
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_NO_SPACE, 0, 0));
		directed.push_back(req_row(REQ_LOAD_COUNT, 1, 0, 64'd0, 1, 1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_ALLOCATED, 64, 0));
		directed.push_back(req_row(REQ_LOAD_WORD, 0, 0, 64'd0, 0, 1, ST_LOAD_DONE, 0, 0));
		// block zero comes back as a valid allocation with the offset off
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_ALLOCATED, 0, 4));
		directed.push_back(cfg_row(CFG_TOTAL_BLOCKS, 0));
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_NO_SPACE, 0, 0));
		// 100 blocks per group: word 1 only counts up to bit 35, so a clear bit 36 is no use
		directed.push_back(cfg_row(CFG_TOTAL_BLOCKS, 200));
		directed.push_back(cfg_row(CFG_BPG, 100));
		directed.push_back(cfg_row(CFG_ONE_OFFSET, 1));
		directed.push_back(req_row(REQ_LOAD_WORD, 0, 1, 64'hFFFF_FFEF_FFFF_FFFF, 0,
			1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_LOAD_WORD, 0, 0, '1, 0, 1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 1, ST_NO_SPACE, 0, 0));
		directed.push_back(req_row(REQ_LOAD_COUNT, 1, 0, 64'd0, 2, 1, ST_LOAD_DONE, 0, 0));
		directed.push_back(req_row(REQ_ALLOC, 0, 0, 64'd0, 0, 0, ST_LOAD_DONE, 0, 0));

		// Hold reset, then release it at a falling edge; the clearing pass keeps s_tready low afterwards
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			row = directed[i];
			if (row.is_cfg) begin
				drain_results();
				write_reg(row.cfg_idx, row.cfg_val);
			end else begin
				send_request(row.req, row.typed, row.want);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// registers change only with nothing in flight
			drain_results();
			write_reg(CFG_TOTAL_BLOCKS, phase_total[p]);
			write_reg(CFG_BPG, phase_bpg[p]);
			write_reg(CFG_ONE_OFFSET, phase_off[p]);
			quiet = (p == RANDOM_PHASES - 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (!quiet && $urandom_range(0, 5) == 0)
					pause_sender($urandom_range(1, 6));
				send_request(random_request(), 1'b0, want);
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (error_count == 0 && results_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### group_bitmap_block_allocator.f
+incdir+rtl/core
rtl/core/gbba_pkg.sv
rtl/core/gbba_cfg.sv
rtl/core/gbba_ffs.sv
rtl/core/gbba_engine.sv
rtl/core/group_bitmap_block_allocator.sv
sim/group_bitmap_block_allocator_tb.sv
